>>> rtl/mf3_pkg.sv
// Shared constants and types for the 3x3 median frame filter.
package mf3_pkg;

    localparam int COLS  = 8;
    localparam int ROWS  = 8;
    localparam int PIX_W = 8;
    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int K_W   = $clog2(COLS + 1);
    localparam int WIN_N = 9;

    typedef logic [PIX_W-1:0] pix_t;

    // 3x3 window, index row*3+col; row 0 is the oldest line, col 2 the newest word
    typedef pix_t [WIN_N-1:0] win_t;

    typedef struct packed {
        logic interior;
        logic frame_end;
    } ctl_t;

endpackage

>>> rtl/mf3_if.sv
// Stream interfaces for the pixel input and the filtered result output.
interface mf3_pix_if;
    logic               valid;
    logic               ready;
    mf3_pkg::pix_t      pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mf3_res_if;
    logic               valid;
    logic               ready;
    mf3_pkg::pix_t      filtered;
    logic               frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

>>> rtl/mf3_median.sv
// Pipelined median-of-nine sorting network with border bypass and output register.
module mf3_median (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mf3_pkg::win_t   in_win,
    input  mf3_pkg::ctl_t   in_ctl,
    output logic            out_valid,
    input  logic            out_ready,
    output mf3_pkg::pix_t   out_filtered,
    output logic            out_frame_end
);

    function automatic mf3_pkg::win_t cx(mf3_pkg::win_t v, int i, int j);
        mf3_pkg::win_t r;
        r = v;
        if (v[j] < v[i])
        begin
            r[i] = v[j];
            r[j] = v[i];
        end
        return r;
    endfunction

    logic           s2_valid_reg;
    mf3_pkg::win_t  s2_win_reg;
    mf3_pkg::ctl_t  s2_ctl_reg;
    mf3_pkg::pix_t  s2_center_reg;

    logic           s3_valid_reg;
    mf3_pkg::win_t  s3_win_reg;
    mf3_pkg::ctl_t  s3_ctl_reg;
    mf3_pkg::pix_t  s3_center_reg;

    logic           o_valid_reg;
    mf3_pkg::pix_t  o_pix_reg;
    logic           o_end_reg;

    mf3_pkg::win_t  net_a;
    mf3_pkg::win_t  net_b;
    mf3_pkg::win_t  net_c;
    logic           o_take;
    logic           s3_free;
    logic           s2_free;

    assign o_take   = !o_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || o_take;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign in_ready = s2_free;

    always_comb
    begin
        net_a = in_win;
        net_a = cx(net_a, 1, 2);
        net_a = cx(net_a, 4, 5);
        net_a = cx(net_a, 7, 8);
        net_a = cx(net_a, 0, 1);
        net_a = cx(net_a, 3, 4);
        net_a = cx(net_a, 6, 7);
        net_a = cx(net_a, 1, 2);
        net_a = cx(net_a, 4, 5);
        net_a = cx(net_a, 7, 8);
    end

    always_comb
    begin
        net_b = s2_win_reg;
        net_b = cx(net_b, 0, 3);
        net_b = cx(net_b, 5, 8);
        net_b = cx(net_b, 4, 7);
        net_b = cx(net_b, 3, 6);
        net_b = cx(net_b, 1, 4);
        net_b = cx(net_b, 2, 5);
        net_b = cx(net_b, 4, 7);
    end

    always_comb
    begin
        net_c = s3_win_reg;
        net_c = cx(net_c, 4, 2);
        net_c = cx(net_c, 6, 4);
        net_c = cx(net_c, 4, 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s2_free)
                s2_valid_reg <= in_valid;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (o_take)
                o_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && in_valid)
        begin
            s2_win_reg    <= net_a;
            s2_ctl_reg    <= in_ctl;
            s2_center_reg <= in_win[4];
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_win_reg    <= net_b;
            s3_ctl_reg    <= s2_ctl_reg;
            s3_center_reg <= s2_center_reg;
        end
        if (o_take && s3_valid_reg)
        begin
            o_pix_reg <= s3_ctl_reg.interior ? net_c[4] : s3_center_reg;
            o_end_reg <= s3_ctl_reg.frame_end;
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_filtered  = o_pix_reg;
    assign out_frame_end = o_end_reg;

endmodule

>>> rtl/median_filter_3x3_frame_core.sv
// Top level: 3x3 median filter over a raster-order frame, line store plus window.
//
//  channel   dir  handshake      payload
//  pixels    in   valid/ready    pixel[7:0]
//  results   out  valid/ready    filtered[7:0], frame_end
//
//  One input word per cycle while running and the pipeline is not stalled; the result
//  for pixel p reaches the output after word p+COLS+1 is taken, through two sort
//  stages and the output register behind the window register.
//  After the last word of a frame, COLS+1 trailing results are read back from the
//  line store one per cycle unless stalled; no input is taken during the readout.
//  Reset clears position and pipeline valids; line store contents are not cleared.
//  Output stalls back up through the pipeline registers; bubbles are squeezed out.
module median_filter_3x3_frame_core (
    input  logic        clk,
    input  logic        rst_n,
    mf3_pix_if.sink     pixels,
    mf3_res_if.source   results
);

    typedef enum logic {ST_RUN, ST_FLUSH} state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [mf3_pkg::COL_W-1:0]      col_reg;
    logic [mf3_pkg::COL_W-1:0]      col_next;
    logic [mf3_pkg::ROW_W-1:0]      row_reg;
    logic [mf3_pkg::ROW_W-1:0]      row_next;
    logic [mf3_pkg::K_W-1:0]        k_reg;
    logic [mf3_pkg::K_W-1:0]        k_next;

    // per column: {pixel two lines up, pixel one line up}
    logic [2*mf3_pkg::PIX_W-1:0]    lb_mem [mf3_pkg::COLS];
    logic [2*mf3_pkg::PIX_W-1:0]    lb_rd_reg;
    logic [mf3_pkg::COL_W-1:0]      lb_addr;

    mf3_pkg::win_t                  win_reg;
    mf3_pkg::win_t                  win_next;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    mf3_pkg::ctl_t                  s1_ctl_reg;
    mf3_pkg::ctl_t                  s1_ctl_next;

    logic                           med_ready;
    logic                           s1_free;
    logic                           acc;
    logic                           last_col;
    logic                           last_pix;
    logic                           emit;
    logic                           flush_load;
    logic                           flush_done;

    assign s1_free      = !s1_valid_reg || med_ready;
    assign pixels.ready = (state_reg == ST_RUN) && s1_free;
    assign acc          = pixels.valid && pixels.ready;
    assign last_col     = col_reg == mf3_pkg::COL_W'(mf3_pkg::COLS - 1);
    assign last_pix     = last_col && (row_reg == mf3_pkg::ROW_W'(mf3_pkg::ROWS - 1));
    assign emit         = (row_reg >= mf3_pkg::ROW_W'(2))
                       || ((row_reg == mf3_pkg::ROW_W'(1)) && (col_reg != '0));
    assign flush_load   = (state_reg == ST_FLUSH) && s1_free;
    assign flush_done   = k_reg == mf3_pkg::K_W'(mf3_pkg::COLS);

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        k_next        = k_reg;
        win_next      = win_reg;
        s1_ctl_next   = s1_ctl_reg;
        s1_valid_next = s1_free ? 1'b0 : s1_valid_reg;

        case (state_reg)
            ST_RUN:
            begin
                lb_addr = col_reg;
                if (acc)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_next[r*3+0] = win_reg[r*3+1];
                        win_next[r*3+1] = win_reg[r*3+2];
                    end
                    win_next[2] = lb_rd_reg[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
                    win_next[5] = lb_rd_reg[mf3_pkg::PIX_W-1:0];
                    win_next[8] = pixels.pixel;
                    s1_valid_next         = emit;
                    s1_ctl_next.interior  = (row_reg >= mf3_pkg::ROW_W'(2))
                                         && (col_reg >= mf3_pkg::COL_W'(2));
                    s1_ctl_next.frame_end = 1'b0;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_pix ? '0 : row_reg + mf3_pkg::ROW_W'(1);
                        lb_addr  = '0;
                    end
                    else
                    begin
                        col_next = col_reg + mf3_pkg::COL_W'(1);
                        lb_addr  = col_next;
                    end
                    if (last_pix)
                    begin
                        state_next = ST_FLUSH;
                        k_next     = '0;
                    end
                end
            end
            ST_FLUSH:
            begin
                lb_addr = (k_reg == '0) ? '0
                        : mf3_pkg::COL_W'(k_reg - mf3_pkg::K_W'(1));
                if (flush_load)
                begin
                    // first trailing word is the right edge of the line above
                    win_next[4] = (k_reg == '0) ? win_reg[5]
                                : lb_rd_reg[mf3_pkg::PIX_W-1:0];
                    s1_valid_next         = 1'b1;
                    s1_ctl_next.interior  = 1'b0;
                    s1_ctl_next.frame_end = flush_done;
                    if (flush_done)
                    begin
                        state_next = ST_RUN;
                        lb_addr    = '0;
                    end
                    else
                    begin
                        k_next  = k_reg + mf3_pkg::K_W'(1);
                        lb_addr = k_reg[mf3_pkg::COL_W-1:0];
                    end
                end
            end
            default:
            begin
                lb_addr    = col_reg;
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            col_reg      <= '0;
            row_reg      <= '0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            k_reg        <= k_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        s1_ctl_reg <= s1_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            lb_mem[col_reg] <= {lb_rd_reg[mf3_pkg::PIX_W-1:0], pixels.pixel};
        lb_rd_reg <= lb_mem[lb_addr];
    end

    mf3_median u_median (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s1_valid_reg),
        .in_ready      (med_ready),
        .in_win        (win_reg),
        .in_ctl        (s1_ctl_reg),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .out_filtered  (results.filtered),
        .out_frame_end (results.frame_end)
    );

    a_last_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
        acc && last_pix |=> (state_reg == ST_FLUSH) && (k_reg == '0))
        else $error("last word of frame did not start trailing readout");

    a_flush_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        flush_load && flush_done |=> s1_valid_reg && s1_ctl_reg.frame_end
            && (state_reg == ST_RUN) && (col_reg == '0) && (row_reg == '0))
        else $error("trailing readout did not end with frame mark and position zero");

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !med_ready |=> $stable(win_reg) && $stable(s1_ctl_reg))
        else $error("window changed while its word was stalled");

    a_no_frame_end_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !s1_ctl_reg.frame_end)
        else $error("frame mark set on a streamed word");

endmodule

>>> tb/tb_top.sv
// Testbench for median_filter_3x3_frame_core: predicts each filtered word and checks it.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_N   = mf3_pkg::ROWS * mf3_pkg::COLS;
    localparam int WORDS_N   = 410;
    localparam int DIRECT_N  = 24;
    localparam int TAIL_WAIT = 40;

    typedef enum int {
        PAT_UNIFORM, PAT_GRADIENT, PAT_TIES, PAT_FLAT, PAT_SPECKLE, PAT_EXTREME
    } frame_pat_t;

    typedef enum int { RX_OPEN, RX_COIN, RX_PULSE, RX_BLOCKS } rx_mode_t;

    class frame_median_checker;
        typedef struct {
            mf3_pkg::pix_t filtered;
            logic          frame_end;
        } filt_word_t;

        mf3_pkg::pix_t frame_px [FRAME_N];
        int            wr_pos;
        filt_word_t    expected_q[$];
        int            errors;
        int            words_in;
        int            words_out;
        int            frames_done;

        function new();
            wr_pos      = 0;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            frames_done = 0;
        endfunction

        function mf3_pkg::pix_t median9(mf3_pkg::pix_t w [9]);
            int lt;
            int le;
            for (int i = 0; i < 9; i++)
            begin
                lt = 0;
                le = 0;
                for (int j = 0; j < 9; j++)
                begin
                    if (w[j] < w[i]) lt++;
                    if (w[j] <= w[i]) le++;
                end
                if (lt <= 4 && le >= 5) return w[i];
            end
            return w[4];
        endfunction

        function mf3_pkg::pix_t window_median(int p);
            int            r;
            int            c;
            int            k;
            mf3_pkg::pix_t w [9];
            r = p / mf3_pkg::COLS;
            c = p % mf3_pkg::COLS;
            if (r == 0 || c == 0 || r == mf3_pkg::ROWS - 1 || c == mf3_pkg::COLS - 1)
                return frame_px[p];
            k = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    w[k] = frame_px[(r + dr) * mf3_pkg::COLS + c + dc];
                    k++;
                end
            end
            return median9(w);
        endfunction

        function void push_result(int p);
            filt_word_t e;
            e.filtered  = window_median(p);
            e.frame_end = (p == FRAME_N - 1);
            expected_q.push_back(e);
        endfunction

        function void take_pixel(mf3_pkg::pix_t px);
            words_in++;
            frame_px[wr_pos] = px;
            if (wr_pos >= mf3_pkg::COLS + 1) push_result(wr_pos - mf3_pkg::COLS - 1);
            if (wr_pos == FRAME_N - 1)
            begin
                for (int p = wr_pos - mf3_pkg::COLS; p < FRAME_N; p++) push_result(p);
                wr_pos = 0;
                frames_done++;
            end
            else
            begin
                wr_pos++;
            end
        endfunction

        function void check_result(mf3_pkg::pix_t filtered, logic frame_end);
            filt_word_t e;
            words_out++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected word: filtered=%0d frame_end=%0b", filtered, frame_end);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (filtered !== e.filtered)
            begin
                $error("filtered: expected %0d, actual %0d", e.filtered, filtered);
                errors++;
            end
            if (frame_end !== e.frame_end)
            begin
                $error("frame_end: expected %0b, actual %0b", e.frame_end, frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mf3_pix_if pix_ch ();
    mf3_res_if res_ch ();

    median_filter_3x3_frame_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch)
    );

    frame_median_checker chk;

    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_stall_left;
    int       rx_tick;
    logic     rx_rdy;

    mf3_pkg::pix_t directed_px [DIRECT_N] = '{
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7,
        8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'hFF
    };

    always #5 clk = ~clk;

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        res_ch.ready = 1'b0;
        chk          = new();
        rx_mode      = RX_OPEN;
        rx_mode_left = 0;
        rx_stall_left = 0;
        rx_tick      = 0;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // accepted words, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready) chk.take_pixel(pix_ch.pixel);
            if (res_ch.valid && res_ch.ready) chk.check_result(res_ch.filtered, res_ch.frame_end);
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(60, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:  rx_rdy = 1'b1;
            RX_COIN:  rx_rdy = 1'($urandom_range(0, 1));
            RX_PULSE: rx_rdy = (rx_tick % 4 == 0);
            default:
            begin
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    rx_rdy = 1'b0;
                end
                else
                begin
                    rx_rdy = 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(3, 12);
                end
            end
        endcase
        res_ch.ready <= rx_rdy;
    end

    task automatic send_word(input mf3_pkg::pix_t px);
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        do @(posedge clk); while (!pix_ch.ready);
    endtask

    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        while (chk.pending() > 0) @(posedge clk);
    endtask

    function automatic mf3_pkg::pix_t frame_pixel(frame_pat_t pat, int idx,
                                                  mf3_pkg::pix_t base);
        int r;
        int c;
        int v;
        r = idx / mf3_pkg::COLS;
        c = idx % mf3_pkg::COLS;
        case (pat)
            PAT_GRADIENT: v = r * 24 + c * 8 + $urandom_range(0, 15);
            PAT_TIES:     v = $urandom_range(0, 2);
            PAT_FLAT:     v = base;
            PAT_SPECKLE:
            begin
                v = base + $urandom_range(0, 6);
                if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 1) ? 255 : 0;
            end
            PAT_EXTREME:  v = $urandom_range(0, 1) ? 255 : 0;
            default:      v = $urandom_range(0, 255);
        endcase
        if (v > 255) v = 255;
        return mf3_pkg::pix_t'(v);
    endfunction

    initial
    begin
        int            burst_left;
        int            gap;
        int            tail;
        frame_pat_t    pat;
        mf3_pkg::pix_t base;
        mf3_pkg::pix_t px;

        burst_left = 0;
        pat        = PAT_UNIFORM;
        base       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < WORDS_N; n++)
        begin
            if (n % FRAME_N == 0)
            begin
                pat  = (n == 0) ? PAT_UNIFORM : frame_pat_t'($urandom_range(0, 5));
                base = mf3_pkg::pix_t'($urandom_range(0, 248));
            end
            if (n == 2 * FRAME_N + 40 || n == 5 * FRAME_N) drain_results();
            if (burst_left == 0)
            begin
                gap = (n / FRAME_N == 3) ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    pix_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            px = (n < DIRECT_N) ? directed_px[n] : frame_pixel(pat, n % FRAME_N, base);
            send_word(px);
            burst_left--;
        end
        pix_ch.valid <= 1'b0;

        tail = 0;
        while (chk.pending() > 0 && tail < 5000)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (TAIL_WAIT) @(posedge clk);
        if (chk.pending() > 0)
        begin
            $error("%0d expected words never arrived", chk.pending());
            chk.errors++;
        end

        $display("Streamed %0d pixels (%0d whole frames, flat/tie/speckle/extreme/random content),",
                 chk.words_in, chk.frames_done);
        $display("checked %0d filtered words under random bursts and output stalls.", chk.words_out);
        if (chk.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
